// File: rtl/upf_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the update packet framer.
// Used by upf_ctrl, upf_datapath and the top level; depends on nothing else.
package upf_pkg;

  localparam int unsigned FILL_W = 6;
  localparam int unsigned POS_W  = 6;

  localparam logic [7:0]  MAGIC0    = 8'h0D;
  localparam logic [7:0]  MAGIC1    = 8'hF0;
  localparam logic [7:0]  CMD_RANGE = 8'h01;
  localparam logic [7:0]  CMD_DONE  = 8'h02;
  localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
  localparam logic [31:0] BASE_RESET = 32'h0010_4000;

  // Packet byte positions.
  localparam logic [POS_W-1:0] POS_MAGIC0 = 6'd0;
  localparam logic [POS_W-1:0] POS_MAGIC1 = 6'd1;
  localparam logic [POS_W-1:0] POS_CMD    = 6'd2;
  localparam logic [POS_W-1:0] POS_LEN    = 6'd4;
  localparam logic [POS_W-1:0] POS_ADDR0  = 6'd8;
  localparam logic [POS_W-1:0] POS_ADDR1  = 6'd9;
  localparam logic [POS_W-1:0] POS_ADDR2  = 6'd10;
  localparam logic [POS_W-1:0] POS_ADDR3  = 6'd11;
  localparam logic [POS_W-1:0] POS_CRC0   = 6'd12;
  localparam logic [POS_W-1:0] POS_CRC1   = 6'd13;
  localparam logic [POS_W-1:0] POS_CRC2   = 6'd14;
  localparam logic [POS_W-1:0] POS_CRC3   = 6'd15;
  localparam logic [POS_W-1:0] POS_FLAGS  = 6'd16;
  localparam logic [POS_W-1:0] POS_DATA   = 6'd20;
  localparam logic [POS_W-1:0] DONE_LAST  = 6'd7;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE    = 1'b1;

  // Input item kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'b0001,
    ST_CRC        = 4'b0010,
    ST_SEND_RANGE = 4'b0100,
    ST_SEND_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic store;         // write the input byte into the chunk store
    logic abort;         // drop the partial chunk and reload the address
    logic gen_start;     // start a pass of the byte generator
    logic gen_send;      // the pass drives the output (otherwise the CRC)
    logic gen_done_pkt;  // the pass produces the update-complete packet
    logic commit;        // advance the address past the sent chunk
  } cmd_t;

  typedef struct packed {
    logic chunk_full;    // the next stored byte fills the chunk
    logic gen_idle;      // generator and its stage are empty
  } status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/upf_ctrl.sv
// Controller state machine of the update packet framer.
// Depends on upf_pkg; drives commands into upf_datapath and reads its status.
module upf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tuser,
  input  logic              s_tlast,
  input  upf_pkg::status_t  status,
  output upf_pkg::cmd_t     cmd
);

  upf_pkg::state_t state;
  upf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= upf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == upf_pkg::ST_IDLE);
    unique case (state)
      upf_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == upf_pkg::KIND_END) begin
            cmd.abort        = 1'b1;
            cmd.gen_start    = 1'b1;
            cmd.gen_send     = 1'b1;
            cmd.gen_done_pkt = 1'b1;
            state_next       = upf_pkg::ST_SEND_DONE;
          end else begin
            cmd.store = 1'b1;
            if (status.chunk_full || s_tlast) begin
              cmd.gen_start = 1'b1;
              state_next    = upf_pkg::ST_CRC;
            end
          end
        end
      end
      upf_pkg::ST_CRC: begin
        if (status.gen_idle) begin
          cmd.gen_start = 1'b1;
          cmd.gen_send  = 1'b1;
          state_next    = upf_pkg::ST_SEND_RANGE;
        end
      end
      upf_pkg::ST_SEND_RANGE: begin
        if (status.gen_idle) begin
          cmd.commit = 1'b1;
          state_next = upf_pkg::ST_IDLE;
        end
      end
      upf_pkg::ST_SEND_DONE: begin
        if (status.gen_idle) begin
          state_next = upf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = upf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/upf_datapath.sv
// Datapath of the update packet framer: chunk store, address and config registers,
// packet byte generator, CRC accumulator and output register. Depends on upf_pkg.
module upf_datapath #(
  parameter int unsigned CHUNK_BYTES = 44
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [upf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic [7:0]                       s_tdata,
  input  upf_pkg::cmd_t                    cmd,
  output upf_pkg::status_t                 status,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [7:0]                       m_tdata,
  output logic                             m_tlast,
  output logic                             m_tuser
);

  localparam int unsigned MEM_AW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam logic [upf_pkg::FILL_W-1:0] CHUNK_LAST = upf_pkg::FILL_W'(CHUNK_BYTES - 1);

  logic [31:0]                 base_address;
  logic                        test_mode;
  logic [31:0]                 next_address;
  logic [upf_pkg::FILL_W-1:0]  fill;
  logic [7:0]                  mem [CHUNK_BYTES];
  logic [7:0]                  rd_data;
  logic [31:0]                 crc;

  logic                        gen_active;
  logic                        send_mode;
  logic                        pkt_type;
  logic [upf_pkg::POS_W-1:0]   pos;
  logic                        s1_v;
  logic [upf_pkg::POS_W-1:0]   s1_pos;
  logic [7:0]                  s1_hdr;
  logic                        s1_isdata;

  logic [6:0]                  fill_p3;
  logic [3:0]                  words;
  logic [upf_pkg::POS_W-1:0]   last_pos;
  logic [upf_pkg::POS_W-1:0]   data_off;
  logic                        in_data;
  logic [7:0]                  hdr;
  logic                        out_free;
  logic                        sink_ready;
  logic                        s1_adv;
  logic                        load;
  logic [7:0]                  s1_byte;
  logic                        s1_crc_field;

  // Length in words is (n + 3) / 4 + 3; the packet's last byte sits at 4 * words + 7.
  assign fill_p3  = {1'b0, fill} + 7'd3;
  assign words    = 4'(fill_p3[6:2]) + 4'd3;
  assign last_pos = pkt_type ? upf_pkg::DONE_LAST
                             : (upf_pkg::POS_W'({words, 2'b00}) + upf_pkg::POS_W'(7));
  assign data_off = pos - upf_pkg::POS_DATA;
  assign in_data  = !pkt_type && (pos >= upf_pkg::POS_DATA) && (data_off < fill);

  always_comb begin
    hdr = '0;
    unique case (pos)
      upf_pkg::POS_MAGIC0: hdr = upf_pkg::MAGIC0;
      upf_pkg::POS_MAGIC1: hdr = upf_pkg::MAGIC1;
      upf_pkg::POS_CMD:    hdr = pkt_type ? upf_pkg::CMD_DONE : upf_pkg::CMD_RANGE;
      upf_pkg::POS_LEN:    hdr = pkt_type ? 8'h00 : {4'h0, words};
      upf_pkg::POS_ADDR0:  hdr = next_address[7:0];
      upf_pkg::POS_ADDR1:  hdr = next_address[15:8];
      upf_pkg::POS_ADDR2:  hdr = next_address[23:16];
      upf_pkg::POS_ADDR3:  hdr = next_address[31:24];
      upf_pkg::POS_CRC0:   hdr = crc[7:0];
      upf_pkg::POS_CRC1:   hdr = crc[15:8];
      upf_pkg::POS_CRC2:   hdr = crc[23:16];
      upf_pkg::POS_CRC3:   hdr = crc[31:24];
      upf_pkg::POS_FLAGS:  hdr = {5'b0_0000, fill[1:0], test_mode};
      default:             hdr = '0;
    endcase
  end

  assign out_free     = !m_tvalid || m_tready;
  assign sink_ready   = send_mode ? out_free : 1'b1;
  assign s1_adv       = s1_v && sink_ready;
  assign load         = gen_active && (!s1_v || s1_adv);
  assign s1_byte      = s1_isdata ? rd_data : s1_hdr;
  assign s1_crc_field = (s1_pos >= upf_pkg::POS_CRC0) && (s1_pos <= upf_pkg::POS_CRC3);

  assign status.chunk_full = (fill == CHUNK_LAST);
  assign status.gen_idle   = !gen_active && !s1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= upf_pkg::BASE_RESET;
      test_mode    <= 1'b0;
      next_address <= upf_pkg::BASE_RESET;
      fill         <= '0;
      gen_active   <= 1'b0;
      send_mode    <= 1'b0;
      pkt_type     <= 1'b0;
      s1_v         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cmd.store) begin
        fill <= fill + upf_pkg::FILL_W'(1);
      end
      if (cmd.abort) begin
        fill         <= '0;
        next_address <= base_address;
      end
      if (cmd.commit) begin
        fill         <= '0;
        next_address <= next_address + {26'h000_0000, fill};
      end
      if (cfg_we) begin
        unique case (cfg_index)
          upf_pkg::REG_BASE_ADDRESS: begin
            base_address <= cfg_data;
            next_address <= cfg_data;
          end
          upf_pkg::REG_TEST_MODE: test_mode <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.gen_start) begin
        gen_active <= 1'b1;
        send_mode  <= cmd.gen_send;
        pkt_type   <= cmd.gen_done_pkt;
      end else if (load && (pos == last_pos)) begin
        gen_active <= 1'b0;
      end

      if (load) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end

      if (send_mode && s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_start) begin
      pos <= '0;
    end else if (load) begin
      pos <= pos + upf_pkg::POS_W'(1);
    end
    if (load) begin
      s1_pos    <= pos;
      s1_hdr    <= hdr;
      s1_isdata <= in_data;
    end
    if (cmd.gen_start && !cmd.gen_send) begin
      crc <= '0;
    end else if (s1_adv && !send_mode && !s1_crc_field) begin
      crc <= upf_pkg::crc_byte(crc, s1_byte);
    end
    if (send_mode && s1_adv) begin
      m_tdata <= s1_byte;
      m_tlast <= (s1_pos == last_pos);
      m_tuser <= pkt_type;
    end
  end

  // Chunk store: one write port at the fill count, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill[MEM_AW-1:0]] <= s_tdata;
    end
    if (load && in_data) begin
      rd_data <= mem[data_off[MEM_AW-1:0]];
    end
  end

endmodule

// File: rtl/upgrade_packet_framer_crc32.sv
// Top level of the firmware update packet framer with CRC-32.
// Instantiates upf_ctrl and upf_datapath; depends on upf_pkg.

// Image bytes arrive one item at a time and are gathered into a chunk of up to
// CHUNK_BYTES bytes. When the chunk fills, or a byte arrives with tlast set, the
// block sends a range-update packet of T = 4 * ceil(n / 4) + 20 bytes for a chunk
// of n bytes (64 bytes for a full 44-byte chunk): magic, command, length in words,
// target address, CRC-32 (polynomial 04C11DB7, MSB first, zero start, no final
// inversion, over all bytes but the CRC field), flags, and the data padded to a
// word. The CRC field precedes the bytes it covers, so each flush runs the packet
// generator twice over the same byte sequence: a first pass feeds the CRC unit,
// a second pass feeds the output. A data byte that does not end a chunk is taken
// without holding the input off; an item that ends a chunk holds the input off
// until both passes are through, as the chunk store has a single read port and
// the output is one byte wide. An end-of-image item (tuser high) drops any partial
// chunk, sends the 8-byte update-complete packet and reloads the target address
// from base_address. A write of base_address also reloads the target address at
// once. The output register lets the last byte of a packet wait on m_tready while
// the next input item is already taken.
module upgrade_packet_framer_crc32 #(
  parameter int unsigned CHUNK_BYTES = 44
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [upf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // last_of_image
  input  logic                           s_tuser,   // [0] kind
  // Output stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast,   // packet_end
  output logic                           m_tuser    // [0] packet_type
);

  upf_pkg::cmd_t    cmd;
  upf_pkg::status_t status;

  upf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  upf_datapath #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// File: rtl/upf_checker.sv
// Port-level checker for the update packet framer, bound to the top level.
// Depends only on the ports of upgrade_packet_framer_crc32.
module upf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output item changed while stalled");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // An end-of-image item busies the block while its packet is sent.
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken right after an end-of-image item");

  // The update-complete packet ends in a zero byte.
  a_done_tail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tuser |-> m_tdata == 8'h00)
    else $error("update-complete packet ends in a nonzero byte");

endmodule

bind upgrade_packet_framer_crc32 upf_checker u_upf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
